/* design/cccnt_pkg.sv */
// shared types and constants for the calendar clock counter
package cccnt_pkg;

   // field widths
   localparam int unsigned MS_W    = 10;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 8;
   localparam int unsigned KIND_W  = 2;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // register index, taken from paddr above the byte offset
   typedef enum logic [0:0] {
      REG_MS_PER_TICK = 1'b0,
      REG_UNUSED      = 1'b1
   } reg_index_type;

   // item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK      = 2'd0,
      KIND_ADD_SEC   = 2'd1,
      KIND_ADD_EIGHT = 2'd2,
      KIND_LOAD      = 2'd3
   } kind_type;

   // calendar limits
   localparam logic [MS_W:0]      MS_LIMIT    = 11'd1000;
   localparam logic [SEC_W:0]     SEC_LIMIT   = 7'd60;
   localparam logic [MIN_W:0]     MIN_LIMIT   = 7'd60;
   localparam logic [HOUR_W:0]    HOUR_LIMIT  = 6'd24;
   localparam logic [HOUR_W:0]    HOUR_SHIFT  = 6'd8;
   localparam logic [MONTH_W:0]   MONTH_LAST  = 5'd12;
   localparam logic [DAY_W-1:0]   LEN_LONG    = 5'd31;
   localparam logic [DAY_W-1:0]   LEN_SHORT   = 5'd30;
   localparam logic [DAY_W-1:0]   LEN_FEB     = 5'd28;
   localparam logic [DAY_W-1:0]   LEN_FEB_LP  = 5'd29;
   localparam logic [YEAR_W-1:0]  LEAP_MASK   = 8'h03;
   localparam logic [MS_W-1:0]    MS_PER_TICK_RESET = 10'd1;

   // calendar time
   typedef struct packed {
      logic [MS_W-1:0]    ms;
      logic [SEC_W-1:0]   sec;
      logic [MIN_W-1:0]   min;
      logic [HOUR_W-1:0]  hour;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } time_type;

   // one input beat as held in the input register
   typedef struct packed {
      kind_type           kind;
      logic [YEAR_W-1:0]  load_year;
      logic [MONTH_W-1:0] load_month;
      logic [DAY_W-1:0]   load_day;
      logic [HOUR_W-1:0]  load_hour;
      logic [MIN_W-1:0]   load_minute;
      logic [SEC_W-1:0]   load_second;
   } req_item_type;

endpackage

/* design/cccnt_if.sv */
// valid/ready channels for request and response beats

interface cccnt_req_if
   import cccnt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [YEAR_W-1:0]  load_year;
   logic [MONTH_W-1:0] load_month;
   logic [DAY_W-1:0]   load_day;
   logic [HOUR_W-1:0]  load_hour;
   logic [MIN_W-1:0]   load_minute;
   logic [SEC_W-1:0]   load_second;

   modport source (
      output valid, kind, load_year, load_month, load_day, load_hour,
             load_minute, load_second,
      input  ready
   );
   modport sink (
      input  valid, kind, load_year, load_month, load_day, load_hour,
             load_minute, load_second,
      output ready
   );
endinterface

interface cccnt_rsp_if
   import cccnt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MS_W-1:0]    millisecond;
   logic [SEC_W-1:0]   second;
   logic [MIN_W-1:0]   minute;
   logic [HOUR_W-1:0]  hour;
   logic [DAY_W-1:0]   day;
   logic [MONTH_W-1:0] month;
   logic [YEAR_W-1:0]  year;

   modport source (
      output valid, millisecond, second, minute, hour, day, month, year,
      input  ready
   );
   modport sink (
      input  valid, millisecond, second, minute, hour, day, month, year,
      output ready
   );
endinterface

/* design/cccnt_csr.sv */
// configuration register block: milliseconds per tick
module cccnt_csr import cccnt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [MS_W-1:0]       ms_per_tick
);

   logic [MS_W-1:0] ms_per_tick_ff;
   logic [MS_W-1:0] ms_per_tick_in;
   reg_index_type   reg_index;
   logic            wr_en;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   // register write decode
   always_comb begin
      ms_per_tick_in = ms_per_tick_ff;
      if (wr_en && (reg_index == REG_MS_PER_TICK)) begin
         ms_per_tick_in = pwdata[MS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= MS_PER_TICK_RESET;
      end else begin
         ms_per_tick_ff <= ms_per_tick_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_MS_PER_TICK: prdata = {{(CSR_DATA_W-MS_W){1'b0}}, ms_per_tick_ff};
         default:         prdata = '0;
      endcase
   end

   assign ms_per_tick = ms_per_tick_ff;

endmodule

/* design/cccnt_step.sv */
// next calendar time for one beat: tick, add second, add eight hours, load
module cccnt_step import cccnt_pkg::*; (
   input  time_type        cur,
   input  req_item_type    item,
   input  logic [MS_W-1:0] ms_per_tick,
   output time_type        nxt
);

   logic [MS_W:0]      ms_sum;
   logic [SEC_W:0]     sec_inc;
   logic [MIN_W:0]     min_inc;
   logic [HOUR_W:0]    hour_inc;
   logic [HOUR_W:0]    hour_shift;
   logic [DAY_W-1:0]   month_len;
   logic [MONTH_W:0]   month_inc;
   time_type           day_adv;
   time_type           sec_adv;
   time_type           eight_adv;

   // length of the current month
   always_comb begin
      unique case (cur.month)
         4'd4, 4'd6, 4'd9, 4'd11: month_len = LEN_SHORT;
         4'd2: month_len = ((cur.year & LEAP_MASK) == '0) ? LEN_FEB_LP : LEN_FEB;
         default: month_len = LEN_LONG;
      endcase
   end

   // day carry into day, month and year
   always_comb begin
      month_inc = {1'b0, cur.month} + 1'b1;
      day_adv   = cur;
      if (cur.day < month_len) begin
         day_adv.day = cur.day + 1'b1;
      end else begin
         day_adv.day = DAY_W'(1);
         if (month_inc <= MONTH_LAST) begin
            day_adv.month = month_inc[MONTH_W-1:0];
         end else begin
            day_adv.month = MONTH_W'(1);
            day_adv.year  = cur.year + 1'b1;
         end
      end
   end

   // one second through the second, minute and hour chain
   always_comb begin
      sec_inc  = {1'b0, cur.sec} + 1'b1;
      min_inc  = {1'b0, cur.min} + 1'b1;
      hour_inc = {1'b0, cur.hour} + 1'b1;
      sec_adv  = cur;
      if (sec_inc < SEC_LIMIT) begin
         sec_adv.sec = sec_inc[SEC_W-1:0];
      end else if (min_inc < MIN_LIMIT) begin
         sec_adv.sec = '0;
         sec_adv.min = min_inc[MIN_W-1:0];
      end else if (hour_inc < HOUR_LIMIT) begin
         sec_adv.sec  = '0;
         sec_adv.min  = '0;
         sec_adv.hour = hour_inc[HOUR_W-1:0];
      end else begin
         sec_adv      = day_adv;
         sec_adv.ms   = cur.ms;
         sec_adv.sec  = '0;
         sec_adv.min  = '0;
         sec_adv.hour = '0;
      end
   end

   // eight-hour shift with a possible day carry
   always_comb begin
      hour_shift = {1'b0, cur.hour} + HOUR_SHIFT;
      eight_adv  = cur;
      if (hour_shift < HOUR_LIMIT) begin
         eight_adv.hour = hour_shift[HOUR_W-1:0];
      end else begin
         eight_adv      = day_adv;
         eight_adv.hour = HOUR_W'(hour_shift - HOUR_LIMIT);
      end
   end

   // pick the result by kind
   always_comb begin
      ms_sum = {1'b0, cur.ms} + {1'b0, ms_per_tick};
      nxt    = cur;
      unique case (item.kind)
         KIND_TICK: begin
            if (ms_sum >= MS_LIMIT) begin
               nxt    = sec_adv;
               nxt.ms = '0;
            end else begin
               nxt.ms = ms_sum[MS_W-1:0];
            end
         end
         KIND_ADD_SEC: begin
            nxt = sec_adv;
         end
         KIND_ADD_EIGHT: begin
            nxt = eight_adv;
         end
         KIND_LOAD: begin
            nxt.ms    = '0;
            nxt.sec   = item.load_second;
            nxt.min   = item.load_minute;
            nxt.hour  = item.load_hour;
            nxt.day   = item.load_day;
            nxt.month = item.load_month;
            nxt.year  = item.load_year;
         end
      endcase
   end

endmodule

/* design/calendar_clock_counter_core.sv */
// calendar clock counter top level: input register, next-time logic, result register
//
// Keeps millisecond, second, minute, hour, day, month and 8-bit year
// (offset from 2000, wrapping at 256). Each request beat is a tick (adds
// ms_per_tick milliseconds, carrying one second at 1000), an add-second, an
// add-eight-hours or a load of the whole time, and gives exactly one response
// beat with the time after the step. One beat is accepted every clock cycle
// while the response side takes beats. Each request waits in the input
// register, then the single-pass next-time logic updates the calendar
// state and the result register together on the same edge. Both
// registers hold under back-pressure, so throughput stays at one beat per
// cycle whenever the response side takes beats. ms_per_tick lives at byte
// address 0 of the APB port, resets to 1 and should be written while idle.
module calendar_clock_counter_core import cccnt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cccnt_req_if.sink             req_bus,
   cccnt_rsp_if.source           rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_item_type    in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   time_type        out_time_ff;
   time_type        time_ff;
   time_type        time_nxt;
   logic [MS_W-1:0] ms_per_tick;
   logic            out_free;
   logic            advance;
   logic            req_take;

   cccnt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .ms_per_tick (ms_per_tick)
   );

   cccnt_step u_step (
      .cur         (time_ff),
      .item        (in_item_ff),
      .ms_per_tick (ms_per_tick),
      .nxt         (time_nxt)
   );

   // pipeline flow control
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   // control and calendar state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         time_ff.ms    <= '0;
         time_ff.sec   <= '0;
         time_ff.min   <= '0;
         time_ff.hour  <= '0;
         time_ff.day   <= DAY_W'(1);
         time_ff.month <= MONTH_W'(1);
         time_ff.year  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            time_ff <= time_nxt;
         end
      end
   end

   // input beat and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind        <= kind_type'(req_bus.kind);
         in_item_ff.load_year   <= req_bus.load_year;
         in_item_ff.load_month  <= req_bus.load_month;
         in_item_ff.load_day    <= req_bus.load_day;
         in_item_ff.load_hour   <= req_bus.load_hour;
         in_item_ff.load_minute <= req_bus.load_minute;
         in_item_ff.load_second <= req_bus.load_second;
      end
      if (advance) begin
         out_time_ff <= time_nxt;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.millisecond = out_time_ff.ms;
   assign rsp_bus.second      = out_time_ff.sec;
   assign rsp_bus.minute      = out_time_ff.min;
   assign rsp_bus.hour        = out_time_ff.hour;
   assign rsp_bus.day         = out_time_ff.day;
   assign rsp_bus.month       = out_time_ff.month;
   assign rsp_bus.year        = out_time_ff.year;

endmodule

/* tb/sv/calendar_clock_counter_core_tb.sv */
// testbench for the calendar clock counter: directed and random beats checked against a predicted calendar
module calendar_clock_counter_core_tb;
   import cccnt_pkg::*;

   // one request beat waiting to be sent
   typedef struct {
      req_item_type beat;
      bit           hold_off;   // send only once every pending result is back
   } queued_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cccnt_req_if req_bus();
   cccnt_rsp_if rsp_bus();

   calendar_clock_counter_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predicted calendar and tick step
   time_type          calendar_now;
   logic [MS_W-1:0]   tick_step;

   queued_beat_type   beat_queue[$];
   time_type          time_queue[$];
   int unsigned       mismatches;

   // sender and receiver pacing
   req_item_type      sent_beat;
   int unsigned       send_wait;
   int                send_run;
   bit                send_steady;
   int unsigned       recv_wait;
   int                recv_run;
   bit                recv_steady;

   // wait before the next beat; long stretches without gaps now and then
   function automatic int unsigned pick_wait(inout int run_left, inout bit steady);
      if (run_left <= 0) begin
         run_left = $urandom_range(80, 10);
         steady   = ($urandom_range(3, 0) == 0);
      end
      run_left--;
      return steady ? 0 : $urandom_range(6, 0);
   endfunction

   // days in a month, month values outside 1..12 count as long months
   function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] month,
                                                   logic [YEAR_W-1:0] year);
      case (month)
         4'd4, 4'd6, 4'd9, 4'd11: return LEN_SHORT;
         4'd2: return ((year & LEAP_MASK) == '0) ? LEN_FEB_LP : LEN_FEB;
         default: return LEN_LONG;
      endcase
   endfunction

   // day carry into month and year
   function automatic void roll_day();
      if (calendar_now.day < month_days(calendar_now.month, calendar_now.year)) begin
         calendar_now.day = calendar_now.day + 1'b1;
      end else begin
         calendar_now.day = 1;
         if (int'(calendar_now.month) >= int'(MONTH_LAST)) begin
            calendar_now.month = 1;
            calendar_now.year  = calendar_now.year + 1'b1;
         end else begin
            calendar_now.month = calendar_now.month + 1'b1;
         end
      end
   endfunction

   // second carry chain, compared wide so loaded values past the limit still carry
   function automatic void bump_second();
      if (int'(calendar_now.sec) + 1 < int'(SEC_LIMIT)) begin
         calendar_now.sec = calendar_now.sec + 1'b1;
      end else begin
         calendar_now.sec = 0;
         if (int'(calendar_now.min) + 1 < int'(MIN_LIMIT)) begin
            calendar_now.min = calendar_now.min + 1'b1;
         end else begin
            calendar_now.min = 0;
            if (int'(calendar_now.hour) + 1 < int'(HOUR_LIMIT)) begin
               calendar_now.hour = calendar_now.hour + 1'b1;
            end else begin
               calendar_now.hour = 0;
               roll_day();
            end
         end
      end
   endfunction

   // apply one beat to the predicted calendar and return the time after it
   function automatic time_type advance_calendar(req_item_type b);
      int hours;
      case (b.kind)
         KIND_TICK: begin
            if (int'(calendar_now.ms) + int'(tick_step) >= int'(MS_LIMIT)) begin
               calendar_now.ms = 0;
               bump_second();
            end else begin
               calendar_now.ms = calendar_now.ms + tick_step;
            end
         end
         KIND_ADD_SEC: bump_second();
         KIND_ADD_EIGHT: begin
            hours = int'(calendar_now.hour) + int'(HOUR_SHIFT);
            if (hours >= int'(HOUR_LIMIT)) begin
               calendar_now.hour = HOUR_W'(hours - int'(HOUR_LIMIT));
               roll_day();
            end else begin
               calendar_now.hour = HOUR_W'(hours);
            end
         end
         default: begin
            calendar_now.year  = b.load_year;
            calendar_now.month = b.load_month;
            calendar_now.day   = b.load_day;
            calendar_now.hour  = b.load_hour;
            calendar_now.min   = b.load_minute;
            calendar_now.sec   = b.load_second;
            calendar_now.ms    = 0;
         end
      endcase
      return calendar_now;
   endfunction

   function automatic void queue_beat(kind_type k, int unsigned y = 0, mo = 0, d = 0,
                                      h = 0, mi = 0, s = 0, bit hold = 0);
      queued_beat_type q;
      q.beat.kind        = k;
      q.beat.load_year   = YEAR_W'(y);
      q.beat.load_month  = MONTH_W'(mo);
      q.beat.load_day    = DAY_W'(d);
      q.beat.load_hour   = HOUR_W'(h);
      q.beat.load_minute = MIN_W'(mi);
      q.beat.load_second = SEC_W'(s);
      q.hold_off         = hold;
      beat_queue.push_back(q);
   endfunction

   // random beat: mostly time steps and loads close to a rollover, some raw loads
   function automatic req_item_type random_beat();
      req_item_type     b;
      int unsigned      pick;
      logic [DAY_W-1:0] len;
      b.load_year   = YEAR_W'($urandom);
      b.load_month  = MONTH_W'($urandom);
      b.load_day    = DAY_W'($urandom);
      b.load_hour   = HOUR_W'($urandom);
      b.load_minute = MIN_W'($urandom);
      b.load_second = SEC_W'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 45)      b.kind = KIND_TICK;
      else if (pick < 65) b.kind = KIND_ADD_SEC;
      else if (pick < 80) b.kind = KIND_ADD_EIGHT;
      else                b.kind = KIND_LOAD;
      if (b.kind == KIND_LOAD && $urandom_range(5, 0) != 0) begin
         b.load_month  = MONTH_W'($urandom_range(12, 1));
         len           = month_days(b.load_month, b.load_year);
         b.load_day    = DAY_W'($urandom_range(len, len - 3));
         b.load_hour   = HOUR_W'($urandom_range(23, 14));
         b.load_minute = MIN_W'($urandom_range(59, 55));
         b.load_second = SEC_W'($urandom_range(59, 50));
      end
      return b;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // register write: setup cycle, then access cycle until pready
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_MS_PER_TICK) tick_step = value[MS_W-1:0];
   endtask

   // wait until every queued beat has gone and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (beat_queue.size() != 0 || req_bus.valid || time_queue.size() != 0);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver, predicts each accepted beat
   always @(posedge clock) begin
      queued_beat_type upcoming;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait     <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) time_queue.push_back(advance_calendar(sent_beat));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait != 0) begin
               send_wait     <= send_wait - 1;
               req_bus.valid <= 1'b0;
            end else if (beat_queue.size() != 0 &&
                         !(beat_queue[0].hold_off && time_queue.size() != 0)) begin
               upcoming = beat_queue.pop_front();
               sent_beat           <= upcoming.beat;
               req_bus.valid       <= 1'b1;
               req_bus.kind        <= upcoming.beat.kind;
               req_bus.load_year   <= upcoming.beat.load_year;
               req_bus.load_month  <= upcoming.beat.load_month;
               req_bus.load_day    <= upcoming.beat.load_day;
               req_bus.load_hour   <= upcoming.beat.load_hour;
               req_bus.load_minute <= upcoming.beat.load_minute;
               req_bus.load_second <= upcoming.beat.load_second;
               send_wait           <= pick_wait(send_run, send_steady);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      time_type    want;
      int unsigned stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_wait     <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (time_queue.size() == 0) begin
            $error("response beat with no time expected");
            mismatches++;
         end else begin
            want = time_queue.pop_front();
            check_field("millisecond", want.ms,    rsp_bus.millisecond);
            check_field("second",      want.sec,   rsp_bus.second);
            check_field("minute",      want.min,   rsp_bus.minute);
            check_field("hour",        want.hour,  rsp_bus.hour);
            check_field("day",         want.day,   rsp_bus.day);
            check_field("month",       want.month, rsp_bus.month);
            check_field("year",        want.year,  rsp_bus.year);
         end
         stall = pick_wait(recv_run, recv_steady);
         recv_wait     <= stall;
         rsp_bus.ready <= (stall == 0);
      end else if (recv_wait != 0) begin
         recv_wait     <= recv_wait - 1;
         rsp_bus.ready <= (recv_wait == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // stimulus
   initial begin
      int unsigned step_values[7];
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_TICK;
      req_bus.load_year   = '0;
      req_bus.load_month  = '0;
      req_bus.load_day    = '0;
      req_bus.load_hour   = '0;
      req_bus.load_minute = '0;
      req_bus.load_second = '0;
      rsp_bus.ready       = 1'b0;
      sent_beat           = '0;
      send_run            = 0;
      recv_run            = 0;
      mismatches          = 0;
      tick_step           = MS_PER_TICK_RESET;
      calendar_now        = '{ms: '0, sec: '0, min: '0, hour: '0, day: 1, month: 1, year: '0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: every kind, year, month and leap-day rollovers, out-of-range loads
      queue_beat(KIND_TICK);
      queue_beat(KIND_ADD_SEC);
      queue_beat(KIND_ADD_EIGHT);
      queue_beat(KIND_LOAD, 255, 12, 31, 23, 59, 59);
      queue_beat(KIND_ADD_SEC);
      queue_beat(KIND_LOAD, 3, 2, 28, 23, 59, 59);
      queue_beat(KIND_ADD_SEC);
      queue_beat(KIND_LOAD, 4, 2, 28, 20, 0, 0);
      queue_beat(KIND_ADD_EIGHT);
      queue_beat(KIND_LOAD, 4, 2, 29, 16, 30, 0);
      queue_beat(KIND_ADD_EIGHT);
      queue_beat(KIND_LOAD, 9, 4, 30, 22, 0, 0);
      queue_beat(KIND_ADD_EIGHT);
      queue_beat(KIND_LOAD, 255, 15, 31, 31, 63, 63);
      queue_beat(KIND_ADD_SEC);
      queue_beat(KIND_LOAD, 0, 0, 31, 31, 0, 0);
      queue_beat(KIND_ADD_EIGHT);
      queue_beat(KIND_LOAD, 1, 13, 0, 20, 0, 0);
      queue_beat(KIND_ADD_EIGHT);
      queue_beat(KIND_LOAD, 0, 0, 0, 0, 0, 0);
      wait_idle();

      // phases over tick steps: exact second, zero, above range, near limit, one, half second, random
      step_values = '{1000, 0, 1023, 999, 1, 500, 0};
      step_values[6] = $urandom_range(1023, 0);
      foreach (step_values[i]) begin
         csr_write(REG_MS_PER_TICK, {CSR_DATA_W'($urandom) << MS_W} | step_values[i]);
         if (i == 2) csr_write(REG_UNUSED, '1);
         queue_beat(KIND_TICK, .hold(1'b1));
         queue_beat(KIND_TICK);
         queue_beat(KIND_TICK);
         for (int n = 0; n < 250; n++) begin
            queued_beat_type q;
            q.beat     = random_beat();
            q.hold_off = (n == 0) || ($urandom_range(199, 0) == 0);
            beat_queue.push_back(q);
         end
         wait_idle();
      end

      // drain, then wait for any stray beat
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
design/cccnt_pkg.sv
design/cccnt_if.sv
design/cccnt_csr.sv
design/cccnt_step.sv
design/calendar_clock_counter_core.sv
tb/sv/calendar_clock_counter_core_tb.sv
